FILE: rtl/cbp_pkg.sv
// Shared constants and types of the command block parser.
package cbp_pkg;

    localparam int BLOCK_BYTES   = 64;
    localparam int CHANNEL_COUNT = 5;

    localparam int POS_W  = $clog2(BLOCK_BYTES + 1);
    localparam int END_W  = $clog2(BLOCK_BYTES + 128);
    localparam int LEN_W  = 6;
    localparam int SKIP_W = LEN_W + 1;
    localparam int CH_W   = 3;
    localparam int OFF_W  = 6;

    localparam logic [7:0] BYTE_END   = 8'hFE;
    localparam logic [7:0] BYTE_PAD   = 8'hFF;
    localparam logic [7:0] BYTE_SKIP  = 8'h00;
    localparam logic [7:0] BYTE_RESET = 8'hFD;

    typedef enum logic [1:0] {
        PH_CMD  = 2'd0,
        PH_RECV = 2'd1,
        PH_SKIP = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_ASSIGNED = 2'd0,
        KIND_RESET    = 2'd1,
        KIND_SKIPPED  = 2'd2,
        KIND_END      = 2'd3
    } kind_t;

endpackage

FILE: rtl/command_block_parser_core.sv
// Command block parser: byte-per-beat decode of channel commands into events.
// Throughput: one input beat per cycle, limited only by the output handshake.
// Every beat passes the input register, then one decode step; a beat that yields an event loads the result register.
// Reset leaves the parser finished: beats are dropped until one carries block_start.
// Reset empties both registers.
module command_block_parser_core (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     block_start,
    input  logic [7:0]               data_byte,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [cbp_pkg::CH_W-1:0]  channel,
    output logic [1:0]               event_kind,
    output logic [cbp_pkg::OFF_W-1:0] command_offset,
    output logic                     parse_done
);
    import cbp_pkg::*;

    logic              in_valid_reg;
    logic              start_reg;
    logic [7:0]        byte_reg;

    logic              out_valid_reg, out_valid_next;
    logic [CH_W-1:0]   channel_reg, channel_next;
    kind_t             kind_reg, kind_next;
    logic [OFF_W-1:0]  offset_reg, offset_next;
    logic              done_reg, done_next;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    phase_t            phase_reg, phase_next;
    logic [SKIP_W-1:0] skip_reg, skip_next;
    logic [OFF_W-1:0]  poff_reg, poff_next;
    logic [LEN_W-1:0]  psend_reg, psend_next;
    logic              fin_reg, fin_next;

    logic              advance;
    logic              step;
    logic [POS_W-1:0]  pos_cur;
    logic [CH_W-1:0]   ch_cur;
    phase_t            phase_cur;
    logic [SKIP_W-1:0] skip_cur;
    logic              fin_cur;
    logic [POS_W-1:0]  pos_inc;
    logic [CH_W-1:0]   ch_inc;
    logic [LEN_W-1:0]  len_byte;
    logic [END_W-1:0]  end_sum;
    logic [SKIP_W-1:0] skip_sum;
    logic [SKIP_W-1:0] skip_dec;
    logic              at_end;
    logic              ch_full;
    logic              too_long;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || advance;
    assign step     = in_valid_reg && advance;

    always_comb
    begin
        pos_cur   = start_reg ? '0 : pos_reg;
        ch_cur    = start_reg ? '0 : ch_reg;
        phase_cur = start_reg ? PH_CMD : phase_reg;
        skip_cur  = start_reg ? '0 : skip_reg;
        fin_cur   = start_reg ? 1'b0 : fin_reg;
        pos_inc   = pos_cur + POS_W'(1);
        ch_inc    = ch_cur + CH_W'(1);
        len_byte  = byte_reg[LEN_W-1:0];
        end_sum   = END_W'(pos_inc) + END_W'(psend_reg) + END_W'(len_byte);
        skip_sum  = SKIP_W'(psend_reg) + SKIP_W'(len_byte);
        skip_dec  = (skip_cur != '0) ? skip_cur - SKIP_W'(1) : skip_cur;
        at_end    = pos_inc >= POS_W'(BLOCK_BYTES);
        ch_full   = ch_inc >= CH_W'(CHANNEL_COUNT);
        too_long  = end_sum >= END_W'(BLOCK_BYTES);
    end

    // next state
    always_comb
    begin
        pos_next   = pos_cur;
        ch_next    = ch_cur;
        phase_next = phase_cur;
        skip_next  = skip_cur;
        poff_next  = poff_reg;
        psend_next = psend_reg;
        fin_next   = fin_cur;
        if (!fin_cur)
        begin
            pos_next = pos_inc;
            unique case (phase_cur)
                PH_SKIP:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == '0)
                        phase_next = PH_CMD;
                end
                PH_RECV:
                begin
                    if (too_long)
                        fin_next = 1'b1;
                    else
                    begin
                        ch_next    = ch_inc;
                        skip_next  = skip_sum;
                        phase_next = (skip_sum != '0) ? PH_SKIP : PH_CMD;
                        fin_next   = ch_full;
                    end
                end
                PH_CMD:
                begin
                    case (byte_reg) inside
                        BYTE_END:
                            fin_next = 1'b1;
                        BYTE_PAD:
                            fin_next = at_end;
                        BYTE_SKIP, BYTE_RESET:
                        begin
                            ch_next  = ch_inc;
                            fin_next = ch_full || at_end;
                        end
                        default:
                        begin
                            poff_next  = OFF_W'(pos_cur);
                            psend_next = len_byte;
                            phase_next = PH_RECV;
                            fin_next   = at_end;
                        end
                    endcase
                end
                default:
                    phase_next = PH_CMD;
            endcase
        end
    end

    // result
    always_comb
    begin
        out_valid_next = 1'b0;
        channel_next   = ch_cur;
        kind_next      = KIND_END;
        offset_next    = '0;
        done_next      = 1'b1;
        if (!fin_cur)
        begin
            unique case (phase_cur)
                PH_RECV:
                begin
                    out_valid_next = 1'b1;
                    if (!too_long)
                    begin
                        kind_next   = KIND_ASSIGNED;
                        offset_next = poff_reg;
                        done_next   = ch_full;
                    end
                end
                PH_CMD:
                begin
                    case (byte_reg)
                        BYTE_END:
                            out_valid_next = 1'b1;
                        BYTE_PAD:
                            out_valid_next = at_end;
                        BYTE_SKIP:
                        begin
                            out_valid_next = 1'b1;
                            kind_next      = KIND_SKIPPED;
                            done_next      = ch_full || at_end;
                        end
                        BYTE_RESET:
                        begin
                            out_valid_next = 1'b1;
                            kind_next      = KIND_RESET;
                            done_next      = ch_full || at_end;
                        end
                        default:
                            out_valid_next = at_end;
                    endcase
                end
                default:
                    out_valid_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            ch_reg        <= '0;
            phase_reg     <= PH_CMD;
            skip_reg      <= '0;
            poff_reg      <= '0;
            psend_reg     <= '0;
            fin_reg       <= 1'b1;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= in_valid_reg && out_valid_next;
            if (step)
            begin
                pos_reg   <= pos_next;
                ch_reg    <= ch_next;
                phase_reg <= phase_next;
                skip_reg  <= skip_next;
                poff_reg  <= poff_next;
                psend_reg <= psend_next;
                fin_reg   <= fin_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            start_reg <= block_start;
            byte_reg  <= data_byte;
        end
        if (step && out_valid_next)
        begin
            channel_reg <= channel_next;
            kind_reg    <= kind_next;
            offset_reg  <= offset_next;
            done_reg    <= done_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign channel        = channel_reg;
    assign event_kind     = kind_reg;
    assign command_offset = offset_reg;
    assign parse_done     = done_reg;

endmodule

FILE: rtl/cbp_checker.sv
// Port-level checks of the command block parser, bound to the top level.
module cbp_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [cbp_pkg::CH_W-1:0]  channel,
    input logic [1:0]               event_kind,
    input logic [cbp_pkg::OFF_W-1:0] command_offset,
    input logic                     parse_done
);
    import cbp_pkg::*;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_kind) && $stable(channel))
    else $error("result beat changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == KIND_END |-> parse_done)
    else $error("end event without parse_done");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind != KIND_ASSIGNED |-> command_offset == '0)
    else $error("offset on a non-assign event");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> channel < CH_W'(CHANNEL_COUNT))
    else $error("channel out of range");

endmodule

bind command_block_parser_core cbp_checker u_cbp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .channel        (channel),
    .event_kind     (event_kind),
    .command_offset (command_offset),
    .parse_done     (parse_done)
);

FILE: tb/tb.sv
// Self-checking testbench for command_block_parser_core: directed table, then random blocks.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cbp_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_BEATS = 300;

    typedef struct packed {
        logic [CH_W-1:0]  ch;
        kind_t            kind;
        logic [OFF_W-1:0] off;
        logic             done;
    } parse_event_t;

    typedef struct {
        logic         start;
        logic [7:0]   data;
        int           reps;
        bit           fixed;
        parse_event_t want;
    } stim_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic             block_start = 1'b0;
    logic [7:0]       data_byte = 8'h00;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [CH_W-1:0]  channel;
    logic [1:0]       event_kind;
    logic [OFF_W-1:0] command_offset;
    logic             parse_done;

    command_block_parser_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .block_start    (block_start),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .channel        (channel),
        .event_kind     (event_kind),
        .command_offset (command_offset),
        .parse_done     (parse_done)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // parser state mirror
    int               byte_pos = 0;
    logic [CH_W-1:0]  chan_now = '0;
    phase_t           phase_now = PH_CMD;
    logic [SKIP_W-1:0] payload_left = '0;
    logic [OFF_W-1:0] len_offset = '0;
    logic [LEN_W-1:0] send_len = '0;
    bit               parse_over = 1'b1;

    parse_event_t     expected_events[$];
    stim_row_t        plan[$];
    int               mismatches = 0;
    int               sent_beats = 0;
    int               quiet_cycles = 0;
    int               tx_idle_pct = 0;
    int               rx_stall_pct = 0;
    bit               want_hold = 1'b0;
    bit               hold_started = 1'b0;
    int               hold_left = 0;
    bit               beat_fixed = 1'b0;
    parse_event_t     beat_want = '0;

    function automatic bit parse_byte(input logic s, input logic [7:0] b,
                                      output parse_event_t ev);
        int               stop;
        logic [CH_W-1:0]  ch;
        if (s)
        begin
            byte_pos     = 0;
            chan_now     = '0;
            phase_now    = PH_CMD;
            payload_left = '0;
            len_offset   = '0;
            send_len     = '0;
            parse_over   = 1'b0;
        end
        ch   = chan_now;
        ev   = '{ch: chan_now, kind: KIND_END, off: '0, done: 1'b1};
        if (parse_over)
            return 1'b0;
        byte_pos++;
        if (phase_now == PH_SKIP)
        begin
            if (payload_left > 0)
                payload_left--;
            if (payload_left == 0)
                phase_now = PH_CMD;
            return 1'b0;
        end
        if (phase_now == PH_RECV)
        begin
            stop = byte_pos + int'(send_len) + int'(b[5:0]);
            if (stop >= BLOCK_BYTES)
            begin
                parse_over = 1'b1;
                return 1'b1;
            end
            chan_now     = chan_now + 1'b1;
            payload_left = SKIP_W'(send_len) + SKIP_W'(b[5:0]);
            phase_now    = (payload_left != 0) ? PH_SKIP : PH_CMD;
            ev           = '{ch: ch, kind: KIND_ASSIGNED, off: len_offset,
                             done: (chan_now >= CHANNEL_COUNT)};
            parse_over   = ev.done;
            return 1'b1;
        end
        if (b == BYTE_END)
        begin
            parse_over = 1'b1;
            return 1'b1;
        end
        if (b == BYTE_PAD)
        begin
            if (byte_pos >= BLOCK_BYTES)
            begin
                parse_over = 1'b1;
                return 1'b1;
            end
            return 1'b0;
        end
        if (b == BYTE_SKIP || b == BYTE_RESET)
        begin
            chan_now   = chan_now + 1'b1;
            ev.ch      = ch;
            ev.kind    = (b == BYTE_SKIP) ? KIND_SKIPPED : KIND_RESET;
            ev.done    = (chan_now >= CHANNEL_COUNT) || (byte_pos >= BLOCK_BYTES);
            parse_over = ev.done;
            return 1'b1;
        end
        len_offset = OFF_W'(byte_pos - 1);
        send_len   = b[5:0];
        phase_now  = PH_RECV;
        if (byte_pos >= BLOCK_BYTES)
        begin
            parse_over = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
        end
    endfunction

    always @(posedge clk)
    begin
        parse_event_t want;
        parse_event_t got;
        bit           has;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                has = parse_byte(block_start, data_byte, want);
                sent_beats++;
                if (beat_fixed)
                begin
                    has  = 1'b1;
                    want = beat_want;
                end
                if (has)
                    expected_events.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                got = '{ch: channel, kind: kind_t'(event_kind), off: command_offset,
                        done: parse_done};
                if (expected_events.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: expected no event, got ch %0d kind %0d off %0d done %0d",
                             $time, got.ch, got.kind, got.off, got.done);
                end
                else
                begin
                    want = expected_events.pop_front();
                    check_field("channel", want.ch, got.ch);
                    check_field("event_kind", want.kind, got.kind);
                    check_field("command_offset", want.off, got.off);
                    check_field("parse_done", want.done, got.done);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL command_block_parser_core");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // receiver: random stalls, one long hold-off on request
    always @(negedge clk)
    begin
        if (want_hold && !hold_started)
        begin
            hold_started = 1'b1;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    task automatic send_beat(input logic s, input logic [7:0] b, input bit fixed,
                             input parse_event_t want);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        block_start <= s;
        data_byte   <= b;
        beat_fixed   = fixed;
        beat_want    = want;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    function automatic void plan_beat(input logic s, input logic [7:0] b, input int n);
        plan.push_back('{start: s, data: b, reps: n, fixed: 1'b0, want: '0});
    endfunction

    function automatic void plan_event(input logic s, input logic [7:0] b,
                                       input logic [CH_W-1:0] ch, input kind_t k,
                                       input logic d);
        plan.push_back('{start: s, data: b, reps: 1, fixed: 1'b1,
                         want: '{ch: ch, kind: k, off: '0, done: d}});
    endfunction

    // one block with random content, sometimes cut short or restarted, then random trailing beats
    task automatic run_block();
        logic [7:0] blk[$];
        logic [7:0] snd;
        logic [7:0] rcv;
        int         lim;
        int         n;
        lim = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : 64 + $urandom_range(0, 4);
        while (blk.size() < lim)
        begin
            case ($urandom_range(0, 9))
                0: blk.push_back(BYTE_SKIP);
                1: blk.push_back(BYTE_RESET);
                2: blk.push_back(BYTE_PAD);
                3: blk.push_back(($urandom_range(0, 3) == 0) ? BYTE_END
                                                             : 8'($urandom_range(0, 255)));
                default:
                begin
                    snd = {2'($urandom_range(0, 3)),
                           6'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                          : $urandom_range(0, 6))};
                    if (snd == BYTE_SKIP || snd >= BYTE_RESET)
                        snd = 8'h41;
                    rcv = {2'($urandom_range(0, 3)),
                           6'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                          : $urandom_range(0, 6))};
                    blk.push_back(snd);
                    blk.push_back(rcv);
                    n = int'(snd[5:0]) + int'(rcv[5:0]);
                    repeat (n)
                        blk.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end
        foreach (blk[i])
            send_beat((i == 0) || ($urandom_range(0, 99) == 0), blk[i], 1'b0, '0);
        repeat ($urandom_range(0, 3))
            send_beat(1'b0, 8'($urandom_range(0, 255)), 1'b0, '0);
    endtask

    initial
    begin
        int target;
        plan_beat(1'b0, 8'h05, 1);
        plan_event(1'b1, BYTE_END, 0, KIND_END, 1'b1);
        plan_beat(1'b0, BYTE_SKIP, 1);
        plan_event(1'b1, BYTE_SKIP, 0, KIND_SKIPPED, 1'b0);
        plan_event(1'b0, BYTE_RESET, 1, KIND_RESET, 1'b0);
        plan_beat(1'b0, BYTE_PAD, 1);
        plan_beat(1'b0, 8'h3F, 1);
        plan_event(1'b0, 8'hFF, 2, KIND_END, 1'b1);
        plan_beat(1'b1, 8'h01, 1);
        plan_beat(1'b0, 8'hC2, 1);
        plan_beat(1'b0, 8'hAA, 1);
        plan_event(1'b1, BYTE_RESET, 0, KIND_RESET, 1'b0);
        plan_beat(1'b0, 8'h80, 1);
        plan_beat(1'b0, 8'h40, 1);
        plan_event(1'b0, BYTE_SKIP, 2, KIND_SKIPPED, 1'b0);
        plan_event(1'b0, BYTE_SKIP, 3, KIND_SKIPPED, 1'b0);
        plan_event(1'b0, BYTE_SKIP, 4, KIND_SKIPPED, 1'b1);
        plan_beat(1'b1, BYTE_PAD, 1);
        plan_beat(1'b0, BYTE_PAD, 62);
        plan_event(1'b0, BYTE_PAD, 0, KIND_END, 1'b1);
        plan_beat(1'b1, BYTE_PAD, 1);
        plan_beat(1'b0, BYTE_PAD, 62);
        plan_event(1'b0, BYTE_SKIP, 0, KIND_SKIPPED, 1'b1);
        plan_beat(1'b1, BYTE_PAD, 1);
        plan_beat(1'b0, BYTE_PAD, 62);
        plan_event(1'b0, 8'h7C, 0, KIND_END, 1'b1);
        plan_beat(1'b1, 8'h3D, 1);
        plan_beat(1'b0, 8'h00, 1);
        plan_beat(1'b0, 8'h5A, 61);
        plan_event(1'b0, BYTE_RESET, 1, KIND_RESET, 1'b1);
        plan_beat(1'b1, 8'h3E, 1);
        plan_event(1'b0, 8'h00, 0, KIND_END, 1'b1);

        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
            repeat (plan[i].reps)
                send_beat(plan[i].start, plan[i].data, plan[i].fixed, plan[i].want);

        target = sent_beats;
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 88; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 88; end
                3: begin tx_idle_pct = 25; rx_stall_pct = 25; end
                default:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                    want_hold    = 1'b1;
                end
            endcase
            target += PHASE_BEATS;
            while (sent_beats < target)
                run_block();
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);
        if (mismatches == 0)
            $display("PASS command_block_parser_core");
        else
            $display("FAIL command_block_parser_core");
        $finish;
    end

endmodule
